// ----- rtl/cmcrc_pkg.sv -----
// cmcrc_pkg: shared constants and helper functions for the msb-first crc unit
// no dependencies; imported by configurable_msb_first_crc_unit and tb_top
package cmcrc_pkg;

  // width mode codes
  localparam logic [1:0] MODE_CRC8  = 2'd0;
  localparam logic [1:0] MODE_CRC16 = 2'd1;
  localparam logic [1:0] MODE_CRC32 = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_WIDTH_MODE = 2'd0;
  localparam logic [1:0] REG_POLY       = 2'd1;
  localparam logic [1:0] REG_INIT       = 2'd2;
  localparam logic [1:0] REG_FINAL_XOR  = 2'd3;

  // reset values of the configuration registers
  localparam logic [1:0]  RESET_WIDTH_MODE = MODE_CRC32;
  localparam logic [31:0] RESET_POLY       = 32'h04C1_1DB7;
  localparam logic [31:0] RESET_INIT       = 32'hFFFF_FFFF;
  localparam logic [31:0] RESET_FINAL_XOR  = 32'hFFFF_FFFF;

  localparam int unsigned CRC_BITS  = 32;
  localparam int unsigned BYTE_BITS = 8;

  // mask of the active crc width; the unused mode code acts as 32 bits
  function automatic logic [CRC_BITS-1:0] crc_mask(input logic [1:0] mode);
    logic [CRC_BITS-1:0] m;
    case (mode)
      MODE_CRC8:  m = 32'h0000_00FF;
      MODE_CRC16: m = 32'h0000_FFFF;
      default:    m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

  // one byte of msb-first polynomial division, eight xor-shift steps
  function automatic logic [CRC_BITS-1:0] crc_absorb(
    input logic [CRC_BITS-1:0]  rem_in,
    input logic [BYTE_BITS-1:0] data,
    input logic [1:0]           mode,
    input logic [CRC_BITS-1:0]  poly
  );
    logic [CRC_BITS-1:0] mask;
    logic [CRC_BITS-1:0] poly_m;
    logic [CRC_BITS-1:0] rem;
    logic                top;
    mask   = crc_mask(mode);
    poly_m = poly & mask;
    // align the byte under the top of the remainder
    case (mode)
      MODE_CRC8:  rem = rem_in ^ {24'h0, data};
      MODE_CRC16: rem = rem_in ^ {16'h0, data, 8'h0};
      default:    rem = rem_in ^ {data, 24'h0};
    endcase
    rem = rem & mask;
    for (int k = 0; k < BYTE_BITS; k++) begin
      case (mode)
        MODE_CRC8:  top = rem[7];
        MODE_CRC16: top = rem[15];
        default:    top = rem[31];
      endcase
      if (top) begin
        rem = ({rem[CRC_BITS-2:0], 1'b0} ^ poly_m) & mask;
      end else begin
        rem = {rem[CRC_BITS-2:0], 1'b0} & mask;
      end
    end
    return rem;
  endfunction

endpackage

// ----- rtl/configurable_msb_first_crc_unit.sv -----
// configurable_msb_first_crc_unit: byte-wise msb-first crc engine, 8/16/32 bits
// depends on cmcrc_pkg for mode codes, register indexes and the byte-division function
//
// Takes one message byte per clock while in_stall is low, returns one result per byte.
// The path is an input register, then the eight division steps of one byte and the
// final xor in a single pass of logic, then the result register. The running
// remainder is the one loop, so each byte completes in that one pass and bytes stream
// at one per clock as long as the output side does not stall. first_byte reloads the
// initial value before the byte; crc_match is set only on a last byte whose crc
// equals the full 32-bit expected_crc. Any configuration write also restarts the
// remainder from the initial value at the new width. Write configuration only while
// no byte is in flight; cfg_ready is always high.
module configurable_msb_first_crc_unit
  import cmcrc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  // input byte channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        first_byte,
  input  logic        last_byte,
  input  logic [31:0] expected_crc,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] crc_value,
  output logic        is_last,
  output logic        crc_match
);

  // configuration registers and running remainder
  logic [1:0]  width_mode;
  logic [31:0] poly;
  logic [31:0] init_value;
  logic [31:0] final_xor;
  logic [31:0] crc_register;

  logic [1:0]  width_mode_next;
  logic [31:0] poly_next;
  logic [31:0] init_value_next;
  logic [31:0] final_xor_next;

  // input stage
  logic        s1_valid;
  logic [7:0]  s1_data;
  logic        s1_first;
  logic        s1_last;
  logic [31:0] s1_expected;

  logic        cfg_fire;
  logic        in_fire;
  logic        s1_fire;
  logic        out_fire;

  logic [31:0] cur_mask;
  logic [31:0] rem_start;
  logic [31:0] rem_new;
  logic [31:0] value;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign out_fire  = out_valid && !out_stall;
  // input stage moves on when the result register is free or being emptied
  assign s1_fire   = s1_valid && (!out_valid || !out_stall);
  assign in_stall  = s1_valid && !s1_fire;
  assign in_fire   = in_valid && !in_stall;

  // configuration write decode
  always_comb begin
    width_mode_next = width_mode;
    poly_next       = poly;
    init_value_next = init_value;
    final_xor_next  = final_xor;
    case (cfg_index)
      REG_WIDTH_MODE: width_mode_next = cfg_data[1:0];
      REG_POLY:       poly_next       = cfg_data;
      REG_INIT:       init_value_next = cfg_data;
      REG_FINAL_XOR:  final_xor_next  = cfg_data;
      default:        width_mode_next = width_mode;
    endcase
  end

  // one byte of division plus the output xor
  always_comb begin
    cur_mask  = crc_mask(width_mode);
    rem_start = s1_first ? (init_value & cur_mask) : (crc_register & cur_mask);
    rem_new   = crc_absorb(rem_start, s1_data, width_mode, poly);
    value     = (rem_new ^ final_xor) & cur_mask;
  end

  // configuration and remainder
  always_ff @(posedge clk) begin
    if (rst) begin
      width_mode   <= RESET_WIDTH_MODE;
      poly         <= RESET_POLY;
      init_value   <= RESET_INIT;
      final_xor    <= RESET_FINAL_XOR;
      crc_register <= RESET_INIT & crc_mask(RESET_WIDTH_MODE);
    end else if (cfg_fire) begin
      width_mode   <= width_mode_next;
      poly         <= poly_next;
      init_value   <= init_value_next;
      final_xor    <= final_xor_next;
      crc_register <= init_value_next & crc_mask(width_mode_next);
    end else if (s1_fire) begin
      crc_register <= rem_new;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_data     <= data_byte;
      s1_first    <= first_byte;
      s1_last     <= last_byte;
      s1_expected <= expected_crc;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= 1'b1;
    end else if (out_fire) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      crc_value <= value;
      is_last   <= s1_last;
      crc_match <= s1_last && (value == s1_expected);
    end
  end

  // remainder never carries bits above the active width
  a_rem_masked: assert property (@(posedge clk) disable iff (rst)
    (crc_register & ~crc_mask(width_mode)) == 32'h0)
    else $error("crc remainder has bits above the crc width");

  // a match is only reported on a last byte
  a_match_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && crc_match |-> is_last)
    else $error("crc match flagged on a byte that is not last");

  // a held byte in the input stage is not dropped
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_fire |=> s1_valid)
    else $error("input stage lost a byte while stalled");

  // an empty input stage never stalls the sender
  a_no_idle_stall: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> !in_stall)
    else $error("input stalled while the input stage is empty");

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// tb_top: self-checking testbench for configurable_msb_first_crc_unit
// depends on cmcrc_pkg and the crc unit rtl; predicts every result from its own crc mirror

module tb_top
  import cmcrc_pkg::*;
();

  // the spare width code, which the unit treats as 32 bits
  localparam logic [1:0] MODE_SPARE = 2'd3;

  typedef struct packed {
    logic [31:0] crc_value;
    logic        is_last;
    logic        crc_match;
  } crc_result_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  data_byte;
  logic        first_byte;
  logic        last_byte;
  logic [31:0] expected_crc;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] crc_value;
  logic        is_last;
  logic        crc_match;

  // mirror of the configuration and the running remainder
  logic [1:0]  cur_mode;
  logic [31:0] cur_poly;
  logic [31:0] cur_init;
  logic [31:0] cur_xor;
  logic [31:0] running_rem;

  crc_result_t pending_crcs[$];
  int unsigned mismatches;
  int unsigned bytes_sent;
  int unsigned results_checked;
  int unsigned match_hits;
  int unsigned cfg_writes;
  bit          idle_on;

  configurable_msb_first_crc_unit dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .data_byte    (data_byte),
    .first_byte   (first_byte),
    .last_byte    (last_byte),
    .expected_crc (expected_crc),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .crc_value    (crc_value),
    .is_last      (is_last),
    .crc_match    (crc_match)
  );

  always #6 clk = ~clk;

  // bits kept by the remainder at a given width code
  function automatic logic [31:0] active_mask(input logic [1:0] mode);
    if (mode == MODE_CRC8) return 32'h0000_00FF;
    if (mode == MODE_CRC16) return 32'h0000_FFFF;
    return 32'hFFFF_FFFF;
  endfunction

  // one byte pushed through eight msb-first division steps
  function automatic logic [31:0] divide_byte(input logic [31:0] rem, input logic [7:0] b,
                                              input logic [1:0] mode, input logic [31:0] poly);
    logic [31:0] msk;
    int unsigned w;
    msk = active_mask(mode);
    w = (mode == MODE_CRC8) ? 8 : (mode == MODE_CRC16) ? 16 : 32;
    rem = (rem ^ (32'(b) << (w - 8))) & msk;
    for (int k = 0; k < 8; k++) begin
      if (rem[w - 1]) begin
        rem = ((rem << 1) ^ (poly & msk)) & msk;
      end else begin
        rem = (rem << 1) & msk;
      end
    end
    return rem;
  endfunction

  // remainder after a byte, with the optional restart from the initial value
  function automatic logic [31:0] next_rem(input logic [31:0] rem, input logic [7:0] b,
                                           input logic f);
    if (f) rem = cur_init & active_mask(cur_mode);
    return divide_byte(rem & active_mask(cur_mode), b, cur_mode, cur_poly);
  endfunction

  // crc the unit will report for a byte, mirror left untouched
  function automatic logic [31:0] preview_crc(input logic [7:0] b, input logic f);
    return (next_rem(running_rem, b, f) ^ cur_xor) & active_mask(cur_mode);
  endfunction

  function automatic void note_error(input string msg);
    if (mismatches < 10) $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endfunction

  // one byte transfer on the input channel, prediction taken at acceptance
  task automatic send_byte(input logic [7:0] b, input logic f, input logic l,
                           input logic [31:0] e);
    int unsigned gap;
    crc_result_t res;
    gap = idle_on ? $urandom_range(0, 5) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    data_byte    <= b;
    first_byte   <= f;
    last_byte    <= l;
    expected_crc <= e;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    running_rem   = next_rem(running_rem, b, f);
    res.crc_value = (running_rem ^ cur_xor) & active_mask(cur_mode);
    res.is_last   = l;
    res.crc_match = l && (res.crc_value == e);
    pending_crcs.push_back(res);
    bytes_sent++;
  endtask

  // stop sending and let every outstanding result drain
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_crcs.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // register write, only with the pipeline empty; any write restarts the remainder
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_WIDTH_MODE: cur_mode = val[1:0];
      REG_POLY:       cur_poly = val;
      REG_INIT:       cur_init = val;
      REG_FINAL_XOR:  cur_xor  = val;
      default:        ;
    endcase
    running_rem = cur_init & active_mask(cur_mode);
    cfg_writes++;
  endtask

  task automatic set_config(input logic [31:0] mode_word, input logic [31:0] poly,
                            input logic [31:0] init, input logic [31:0] fx);
    write_reg(REG_WIDTH_MODE, mode_word);
    write_reg(REG_POLY, poly);
    write_reg(REG_INIT, init);
    write_reg(REG_FINAL_XOR, fx);
  endtask

  // result side: random stall before each transfer
  initial begin : result_stall
    int unsigned stall_len;
    out_stall <= 1'b0;
    forever begin
      stall_len = idle_on ? $urandom_range(0, 5) : 0;
      if (stall_len != 0) begin
        out_stall <= 1'b1;
        repeat (stall_len) @(posedge clk);
        out_stall <= 1'b0;
      end
      @(posedge clk);
      while (!(out_valid && !out_stall)) @(posedge clk);
    end
  end

  // compare each result transfer with the oldest prediction
  always @(posedge clk) begin : check_results
    crc_result_t want;
    if (!rst && out_valid && !out_stall) begin
      results_checked++;
      if (pending_crcs.size() == 0) begin
        note_error($sformatf("unexpected result crc_value=%h is_last=%b crc_match=%b",
                             crc_value, is_last, crc_match));
      end else begin
        want = pending_crcs.pop_front();
        if (want.crc_value !== crc_value || want.is_last !== is_last ||
            want.crc_match !== crc_match) begin
          note_error($sformatf("exp crc=%h last=%b match=%b, got crc=%h last=%b match=%b",
                               want.crc_value, want.is_last, want.crc_match,
                               crc_value, is_last, crc_match));
        end
        if (crc_match === 1'b1) match_hits++;
      end
    end
  end

  // check string "123456789" at reset settings, first byte without the restart flag
  task automatic test_reset_defaults();
    idle_on = 1'b1;
    for (int i = 0; i < 9; i++) begin
      send_byte(8'h31 + 8'(i), 1'b0, i == 8, (i == 8) ? 32'hFC89_1918 : 32'h0);
    end
  endtask

  // extreme byte and expected values, continuation across a last byte
  task automatic test_field_extremes();
    send_byte(8'h00, 1'b1, 1'b1, 32'h0000_0000);
    send_byte(8'hFF, 1'b1, 1'b0, 32'hFFFF_FFFF);
    send_byte(8'hFF, 1'b0, 1'b1, 32'hFFFF_FFFF);
    send_byte(8'h00, 1'b0, 1'b1, preview_crc(8'h00, 1'b0));
  endtask

  // every width code with extreme settings; wide expected values never match
  task automatic test_width_modes();
    logic [31:0] c;
    set_config({30'h0, MODE_CRC8}, 32'h0000_0007, 32'h0, 32'h0);
    c = preview_crc(8'hA5, 1'b1);
    send_byte(8'hA5, 1'b1, 1'b1, c);
    c = preview_crc(8'h5A, 1'b0);
    send_byte(8'h5A, 1'b0, 1'b1, c | 32'h0000_0100);
    set_config({30'h0, MODE_CRC16}, 32'h0, 32'hFFFF_FFFF, 32'h0);
    c = preview_crc(8'h80, 1'b1);
    send_byte(8'h80, 1'b1, 1'b1, c);
    c = preview_crc(8'h01, 1'b0);
    send_byte(8'h01, 1'b0, 1'b1, c | 32'h8000_0000);
    set_config({30'h0, MODE_CRC32}, 32'h04C1_1DB7, 32'h0, 32'hFFFF_FFFF);
    c = preview_crc(8'h7F, 1'b1);
    send_byte(8'h7F, 1'b1, 1'b1, c);
    c = preview_crc(8'hFE, 1'b0);
    send_byte(8'hFE, 1'b0, 1'b1, c ^ 32'h1);
    set_config({30'h0, MODE_SPARE}, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    c = preview_crc(8'hC3, 1'b1);
    send_byte(8'hC3, 1'b1, 1'b1, c);
    // a register write mid-message restarts the remainder
    send_byte(8'h3C, 1'b0, 1'b0, 32'h0);
    write_reg(REG_FINAL_XOR, 32'h1234_5678);
    c = preview_crc(8'h3C, 1'b0);
    send_byte(8'h3C, 1'b0, 1'b1, c);
  endtask

  // random settings per phase, mostly well-formed messages with some broken framing
  task automatic test_random_messages();
    logic [1:0]  mode;
    logic [31:0] poly;
    logic [31:0] init;
    logic [31:0] fx;
    logic [31:0] e;
    logic [7:0]  b;
    logic        f;
    logic        l;
    int unsigned sent;
    int unsigned len;
    for (int p = 0; p < 12; p++) begin
      mode = 2'($urandom_range(0, 3));
      case ($urandom_range(0, 4))
        0: poly = 32'h0;
        1: poly = 32'hFFFF_FFFF;
        2: poly = (mode == MODE_CRC8) ? 32'h07 :
                  (mode == MODE_CRC16) ? (($urandom_range(0, 1) != 0) ? 32'h1021 : 32'h8005) :
                  32'h04C1_1DB7;
        default: poly = $urandom();
      endcase
      case ($urandom_range(0, 2))
        0: init = 32'h0;
        1: init = 32'hFFFF_FFFF;
        default: init = $urandom();
      endcase
      case ($urandom_range(0, 2))
        0: fx = 32'h0;
        1: fx = 32'hFFFF_FFFF;
        default: fx = $urandom();
      endcase
      idle_on = ($urandom_range(0, 3) != 0);
      // upper bits of the width register write are don't-care
      set_config(($urandom() & ~32'h3) | 32'(mode), poly, init, fx);
      sent = 0;
      while (sent < 100) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        for (int i = 0; i < len; i++) begin
          b = 8'($urandom());
          f = (i == 0);
          l = (i == len - 1);
          if ($urandom_range(0, 9) == 0) begin
            f = 1'($urandom());
            l = 1'($urandom());
          end
          e = $urandom();
          if (l) begin
            case ($urandom_range(0, 3))
              0, 1: e = preview_crc(b, f);
              2:    e = preview_crc(b, f) ^ (32'h1 << $urandom_range(0, 31));
              default: ;
            endcase
          end
          send_byte(b, f, l, e);
          sent++;
        end
      end
    end
  endtask

  // streaming at full rate, no gaps and no stalls
  task automatic test_back_to_back();
    logic [7:0] b;
    logic       l;
    idle_on = 1'b0;
    set_config({30'h0, RESET_WIDTH_MODE}, RESET_POLY, RESET_INIT, RESET_FINAL_XOR);
    for (int i = 0; i < 60; i++) begin
      b = 8'($urandom());
      l = (i % 6 == 5);
      send_byte(b, i % 6 == 0, l, l ? preview_crc(b, i % 6 == 0) : $urandom());
    end
  endtask

  initial begin
    rst          <= 1'b1;
    cfg_valid    <= 1'b0;
    cfg_index    <= REG_WIDTH_MODE;
    cfg_data     <= 32'h0;
    in_valid     <= 1'b0;
    data_byte    <= 8'h0;
    first_byte   <= 1'b0;
    last_byte    <= 1'b0;
    expected_crc <= 32'h0;
    cur_mode     = RESET_WIDTH_MODE;
    cur_poly     = RESET_POLY;
    cur_init     = RESET_INIT;
    cur_xor      = RESET_FINAL_XOR;
    running_rem  = RESET_INIT & active_mask(RESET_WIDTH_MODE);
    idle_on      = 1'b1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_field_extremes();
    test_width_modes();
    test_random_messages();
    test_back_to_back();

    // drain, then watch a little longer for stray results
    idle_on = 1'b1;
    wait_idle();
    repeat (10) @(posedge clk);
    if (pending_crcs.size() != 0) note_error("predictions left without a result");

    $display("covered %0d bytes over all width codes, %0d results checked, %0d crc matches",
             bytes_sent, results_checked, match_hits);
    $display("%0d register writes, %0d mismatches", cfg_writes, mismatches);
    if (mismatches == 0) begin
      $display("configurable_msb_first_crc_unit verification clean");
    end else begin
      $display("configurable_msb_first_crc_unit verification failed");
    end
    $finish;
  end

  // hard stop in case the handshake hangs
  initial begin
    #5_000_000;
    $display("configurable_msb_first_crc_unit verification failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/cmcrc_pkg.sv
rtl/configurable_msb_first_crc_unit.sv
test/tb_top.sv
